/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the ranged random generator.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Implication checked on the following edge.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* rtl/core/pmrr_pkg.sv */
// Package for the ranged random generator: widths, constants, action codes.
// No dependencies.
package pmrr_pkg;

  localparam int STATE_W = 31;
  localparam int VALUE_W = 32;
  localparam int OPA_W   = 17;
  localparam int OPB_W   = 33;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int FRAC_SHIFT = 17;

  localparam logic [OPA_W-1:0]   MS_MULT  = 17'd48271;
  localparam logic [VALUE_W-1:0] MS_MOD   = 32'h7fff_ffff;
  localparam logic [STATE_W-1:0] MS_RESET = 31'h0000_1234;

  localparam logic [1:0] ACT_INT  = 2'd0;
  localparam logic [1:0] ACT_FRAC = 2'd1;
  localparam logic [1:0] ACT_SEED = 2'd2;

endpackage

/* rtl/core/pmrr_mul.sv */
// Shared 17 x 33 unsigned multiplier with a registered product.
// Depends on pmrr_pkg.
module pmrr_mul (
  input  logic                         clk,
  input  logic [pmrr_pkg::OPA_W-1:0]   op_a,
  input  logic [pmrr_pkg::OPB_W-1:0]   op_b,
  output logic [pmrr_pkg::PROD_W-1:0]  prod
);
  import pmrr_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

/* rtl/core/pmrr_fold.sv */
// Mersenne fold of a 47-bit product modulo 2^31-1, one conditional subtract.
// Depends on pmrr_pkg.
module pmrr_fold (
  input  logic [46:0]                   prod,
  output logic [pmrr_pkg::STATE_W-1:0]  state_out
);
  import pmrr_pkg::*;

  logic [VALUE_W-1:0] sum;

  always_comb begin
    sum = {1'b0, prod[30:0]} + {16'b0, prod[46:31]};
    if (sum >= MS_MOD) begin
      state_out = STATE_W'(sum - MS_MOD);
    end else begin
      state_out = sum[STATE_W-1:0];
    end
  end

endmodule

/* rtl/core/park_miller_ranged_random.sv */
// Ranged minimal-standard random generator, multiplier 48271.
// Draws pass S_GEN, S_FOLD, S_SCALE, S_ADJ, S_DONE; seed loads go to S_DONE.
// No new item is taken until the result reaches the output register, as the
// one shared multiplier serves twice per draw and S_DONE waits on out_free.
// Reset (rst, synchronous): state returns to 0x1234, no result pending.
module park_miller_ranged_random (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic signed [31:0]           from_value,
  input  logic signed [31:0]           to_value,
  input  logic signed [31:0]           seed_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           result_value,
  output logic [30:0]                  state_now
);
  import pmrr_pkg::*;
  `include "assert_macros.svh"

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an item
  localparam logic [2:0] S_GEN   = 3'd1;  // multiplier: 48271 * state
  localparam logic [2:0] S_FOLD  = 3'd2;  // fold product, new state, fraction
  localparam logic [2:0] S_SCALE = 3'd3;  // multiplier: (2k+1) * |span|
  localparam logic [2:0] S_ADJ   = 3'd4;  // floor, sign, add lower bound
  localparam logic [2:0] S_DONE  = 3'd5;  // hand result to output register

  logic [2:0]              st;
  logic [STATE_W-1:0]      rng_state;
  logic [OPA_W-1:0]        num;       // 2k+1
  logic [OPB_W-1:0]        mag;       // |span| or |difference|
  logic                    neg;       // difference is negative (fraction draw)
  logic [VALUE_W-1:0]      lo;        // lower bound after optional swap
  logic [VALUE_W-1:0]      res;

  logic                    accept;
  logic                    out_free;
  logic [OPA_W-1:0]        op_a;
  logic [OPB_W-1:0]        op_b;
  logic [PROD_W-1:0]       prod;
  logic [STATE_W-1:0]      fold_state;

  // range preparation from the input ports
  logic                    swap;
  logic [VALUE_W-1:0]      lo_in;
  logic [VALUE_W-1:0]      hi_in;
  logic signed [33:0]      diff;

  // final scaling
  logic [PROD_W:0]         rnd;
  logic [33:0]             q_mag;
  logic [33:0]             q;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (st != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Integer draw swaps reversed bounds and adds one; fraction draw keeps the
  // signed difference as is.
  always_comb begin
    swap  = (action == ACT_INT) && (to_value < from_value);
    lo_in = swap ? to_value : from_value;
    hi_in = swap ? from_value : to_value;
    diff  = 34'(signed'({{2{hi_in[31]}}, hi_in})) - 34'(signed'({{2{lo_in[31]}}, lo_in}));
    if (action == ACT_INT) begin
      diff = diff + 34'sd1;
    end
  end

  // Shared multiplier operands: generator step, then range scaling.
  always_comb begin
    if (st == S_SCALE) begin
      op_a = num;
      op_b = mag;
    end else begin
      op_a = MS_MULT;
      op_b = {2'b00, rng_state};
    end
  end

  pmrr_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  pmrr_fold u_fold (
    .prod      (prod[46:0]),
    .state_out (fold_state)
  );

  // floor(num*|d| / 2^17), rounded away from zero when d is negative,
  // which makes the signed result floor toward minus infinity
  always_comb begin
    rnd   = {1'b0, prod} + (neg ? (PROD_W+1)'((1 << FRAC_SHIFT) - 1) : '0);
    q_mag = rnd[FRAC_SHIFT+33:FRAC_SHIFT];
    q     = neg ? (34'd0 - q_mag) : q_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      rng_state <= MS_RESET;
      out_valid <= 1'b0;
    end else begin
      // taken result leaves unless a new one is loaded on this edge
      if (out_valid && !out_stall && st != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            lo  <= lo_in;
            neg <= diff[33];
            mag <= diff[33] ? OPB_W'(34'd0 - diff) : diff[OPB_W-1:0];
            res <= '0;
            case (action)
              ACT_INT, ACT_FRAC: st <= S_GEN;
              ACT_SEED: begin
                rng_state <= (seed_value[30:0] == '0) ? STATE_W'(1) : seed_value[30:0];
                st        <= S_DONE;
              end
              default: st <= S_DONE;  // unused action: no state change
            endcase
          end
        end
        S_GEN: st <= S_FOLD;
        S_FOLD: begin
          rng_state <= fold_state;
          num       <= {fold_state[15:0], 1'b1};
          st        <= S_SCALE;
        end
        S_SCALE: st <= S_ADJ;
        S_ADJ: begin
          res <= lo + q[VALUE_W-1:0];
          st  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result_value <= res;
            state_now    <= rng_state;
            out_valid    <= 1'b1;
            st           <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // folded state is always fully reduced
  `ASSERT_NOW(a_fold_reduced, clk, rst, st == S_SCALE, rng_state != STATE_W'(MS_MOD))
  // a seed load never leaves a zero state
  `ASSERT_NEXT(a_seed_nonzero, clk, rst, accept && action == ACT_SEED, rng_state != '0)
  // an accepted item always starts the sequencer
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, st != S_IDLE)
  // a result is only handed over from the final step
  `ASSERT_NEXT(a_out_from_done, clk, rst, !out_valid && st != S_DONE, !out_valid)

endmodule
